/* hw/rtl/tkit_pkg.sv */
// shared types and constants for the two-key interning table
`default_nettype none
package tkit_pkg;
    localparam int CONCEPT_BITS   = 16;
    localparam int RELATION_BITS  = 16;
    localparam int SLOT_COUNT     = 256;
    localparam int SINGLE_ENTRIES = 128;
    localparam int PAIR_ENTRIES   = 128;
    localparam int SLOT_W         = $clog2(SLOT_COUNT + 1);
    localparam int SIDX_W         = $clog2(SINGLE_ENTRIES);
    localparam int PIDX_W         = $clog2(PAIR_ENTRIES);
    localparam int SFILL_W        = $clog2(SINGLE_ENTRIES + 1);
    localparam int PFILL_W        = $clog2(PAIR_ENTRIES + 1);
    localparam int IDX_W          = (SIDX_W > PIDX_W) ? SIDX_W : PIDX_W;
    localparam int FILL_W         = (SFILL_W > PFILL_W) ? SFILL_W : PFILL_W;
    localparam int PKEY_W         = CONCEPT_BITS + RELATION_BITS;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_MISSING  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic           load;
        logic           scan;
        logic           insert;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic             hit;
        logic             ins;
        logic [FILL_W-1:0] fill;
        logic             full;
        logic [7:0]       slot;
    } t_dp_stat;
endpackage
`default_nettype wire

/* hw/rtl/tkit_if.sv */
// valid/ready channel interfaces for request and result items
`default_nettype none
interface tkit_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        key_kind;
    logic [15:0] concept_key;
    logic [15:0] relation_key;
    modport source (output valid, command, key_kind, concept_key, relation_key, input ready);
    modport sink (input valid, command, key_kind, concept_key, relation_key, output ready);
endinterface

interface tkit_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] slot_number;
    modport source (output valid, status, slot_number, input ready);
    modport sink (input valid, status, slot_number, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tkit_datapath.sv */
// key memories, request registers, fill counters and slot allocator
`default_nettype none
module tkit_datapath (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire tkit_pkg::t_dp_cmd i_cmd,
    input  wire                    i_command,
    input  wire                    i_key_kind,
    input  wire [15:0]             i_concept_key,
    input  wire [15:0]             i_relation_key,
    output tkit_pkg::t_dp_stat     o_stat
);
    logic [tkit_pkg::CONCEPT_BITS-1:0]  r_single_keys [tkit_pkg::SINGLE_ENTRIES];
    logic [7:0]                         r_single_slots [tkit_pkg::SINGLE_ENTRIES];
    logic [tkit_pkg::PKEY_W-1:0]        r_pair_keys [tkit_pkg::PAIR_ENTRIES];
    logic [7:0]                         r_pair_slots [tkit_pkg::PAIR_ENTRIES];
    logic [tkit_pkg::SFILL_W-1:0]       r_single_fill;
    logic [tkit_pkg::PFILL_W-1:0]       r_pair_fill;
    logic [tkit_pkg::SLOT_W-1:0]        r_slots_used;
    logic                               r_ins, r_pair, r_hit;
    logic [tkit_pkg::CONCEPT_BITS-1:0]  r_concept;
    logic [tkit_pkg::RELATION_BITS-1:0] r_relation;
    logic [tkit_pkg::CONCEPT_BITS-1:0]  r_rd_single;
    logic [tkit_pkg::PKEY_W-1:0]        r_rd_pair;
    logic [7:0]                         r_rd_sslot, r_rd_pslot, r_slot;
    logic                               r_rd_valid;
    logic                               w_match;
    logic [tkit_pkg::SIDX_W-1:0]        w_sidx;
    logic [tkit_pkg::PIDX_W-1:0]        w_pidx;

    assign w_sidx = i_cmd.idx[tkit_pkg::SIDX_W-1:0];
    assign w_pidx = i_cmd.idx[tkit_pkg::PIDX_W-1:0];
    assign w_match = r_rd_valid && (r_pair ? (r_rd_pair == {r_relation, r_concept})
                                           : (r_rd_single == r_concept));

    always_ff @(posedge i_clk) begin
        r_rd_single <= r_single_keys[w_sidx];
        r_rd_sslot  <= r_single_slots[w_sidx];
        r_rd_pair   <= r_pair_keys[w_pidx];
        r_rd_pslot  <= r_pair_slots[w_pidx];
        if (i_cmd.insert && !r_pair) begin
            r_single_keys[r_single_fill[tkit_pkg::SIDX_W-1:0]]  <= r_concept;
            r_single_slots[r_single_fill[tkit_pkg::SIDX_W-1:0]] <= r_slots_used[7:0];
        end
        if (i_cmd.insert && r_pair) begin
            r_pair_keys[r_pair_fill[tkit_pkg::PIDX_W-1:0]]  <= {r_relation, r_concept};
            r_pair_slots[r_pair_fill[tkit_pkg::PIDX_W-1:0]] <= r_slots_used[7:0];
        end
        if (i_cmd.load) begin
            r_ins      <= i_command;
            r_pair     <= i_key_kind;
            r_concept  <= i_concept_key[tkit_pkg::CONCEPT_BITS-1:0];
            r_relation <= i_relation_key[tkit_pkg::RELATION_BITS-1:0];
        end
        if (w_match && !r_hit) r_slot <= r_pair ? r_rd_pslot : r_rd_sslot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single_fill <= '0;
            r_pair_fill   <= '0;
            r_slots_used  <= '0;
            r_hit         <= 1'b0;
            r_rd_valid    <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.scan;
            if (i_cmd.load) r_hit <= 1'b0;
            else if (w_match) r_hit <= 1'b1;
            if (i_cmd.insert) begin
                r_slots_used <= r_slots_used + 1'b1;
                if (r_pair) r_pair_fill <= r_pair_fill + 1'b1;
                else r_single_fill <= r_single_fill + 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.hit  = r_hit;
        o_stat.ins  = r_ins;
        o_stat.fill = r_pair ? tkit_pkg::FILL_W'(r_pair_fill) : tkit_pkg::FILL_W'(r_single_fill);
        o_stat.full = (r_slots_used >= tkit_pkg::SLOT_W'(tkit_pkg::SLOT_COUNT)) ||
                      (r_pair ? (r_pair_fill >= tkit_pkg::PFILL_W'(tkit_pkg::PAIR_ENTRIES))
                              : (r_single_fill >= tkit_pkg::SFILL_W'(tkit_pkg::SINGLE_ENTRIES)));
        o_stat.slot = r_hit ? r_slot : r_slots_used[7:0];
    end
endmodule
`default_nettype wire

/* hw/rtl/tkit_ctrl.sv */
// sequencer: accepts a request, scans the key table, decides and emits the result
`default_nettype none
module tkit_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    tkit_req_if.sink                req,
    tkit_rsp_if.source              rsp,
    input  wire tkit_pkg::t_dp_stat i_stat,
    output tkit_pkg::t_dp_cmd       o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                r_state, n_state;
    logic [tkit_pkg::FILL_W-1:0] r_idx, n_idx;
    logic                      r_valid;
    logic [1:0]                r_status;
    logic [7:0]                r_slot;
    logic                      w_take;

    assign req.ready = (r_state == S_IDLE) && (!r_valid || rsp.ready);
    assign w_take = req.valid && req.ready;
    assign rsp.valid = r_valid;
    assign rsp.status = r_status;
    assign rsp.slot_number = r_slot;

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        o_cmd.load = w_take;
        o_cmd.scan = 1'b0;
        o_cmd.insert = 1'b0;
        o_cmd.idx = r_idx[tkit_pkg::IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (w_take) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit || r_idx >= i_stat.fill) n_state = S_DRAIN;
                else begin
                    o_cmd.scan = 1'b1;
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                n_state = S_IDLE;
                o_cmd.insert = !i_stat.hit && i_stat.ins && !i_stat.full;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (r_state == S_DONE) r_valid <= 1'b1;
            else if (rsp.ready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            if (i_stat.hit) begin
                r_status <= tkit_pkg::ST_FOUND;
                r_slot   <= i_stat.slot;
            end else if (!i_stat.ins) begin
                r_status <= tkit_pkg::ST_MISSING;
                r_slot   <= '0;
            end else if (i_stat.full) begin
                r_status <= tkit_pkg::ST_FULL;
                r_slot   <= '0;
            end else begin
                r_status <= tkit_pkg::ST_INSERTED;
                r_slot   <= i_stat.slot;
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/two_key_interning_table_core.sv */
// top level: maps concept keys and (relation, concept) pairs to shared slot numbers
// use: send a request item on i_req (command, key_kind, concept_key, relation_key);
// one result item (status, slot_number) comes back on o_rsp for each request.
// status 0 found, 1 newly inserted, 2 not found (lookup only), 3 table full.
// one request is worked at a time: the key table of the request's kind is read
// one entry per cycle from its single read port. the scan ends at a hit or
// once it has passed every key already held in that table (up to 128). the next
// request can be taken in the cycle in which the result leaves.
// the result sits in an output register; a new request is taken while it waits,
// provided the receiver takes it in the same cycle or it was already taken.
// a stalled receiver holds the result and the block takes no further request.
// reset (synchronous, active low) empties both tables and the slot allocator at once.
`default_nettype none
module two_key_interning_table_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tkit_req_if.sink   i_req,
    tkit_rsp_if.source o_rsp
);
    tkit_pkg::t_dp_cmd  w_cmd;
    tkit_pkg::t_dp_stat w_stat;

    tkit_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(i_req), .rsp(o_rsp),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    tkit_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_command(i_req.command), .i_key_kind(i_req.key_kind),
        .i_concept_key(i_req.concept_key), .i_relation_key(i_req.relation_key),
        .o_stat(w_stat)
    );
endmodule
`default_nettype wire
